// ===== rtl/core/csuj_pkg.sv =====
package csuj_pkg;

  // geometry of the store and the journal
  localparam int ROW_BITS       = 6;
  localparam int COLUMN_BITS    = 6;
  localparam int ITEM_BITS      = 16;
  localparam int JOURNAL_DEPTH  = 99;

  localparam int CELL_ADDR_BITS = ROW_BITS + COLUMN_BITS;
  localparam int JENTRY_BITS    = CELL_ADDR_BITS + ITEM_BITS;
  localparam int SLOT_BITS      = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
  localparam int COUNT_BITS     = $clog2(JOURNAL_DEPTH + 1);

  // configuration registers
  localparam int GRID_BITS      = 7;
  localparam logic [GRID_BITS-1:0] GRID_RESET = GRID_BITS'(64);
  localparam int ROW_CMP_BITS   = (ROW_BITS > GRID_BITS) ? ROW_BITS : GRID_BITS;
  localparam int COL_CMP_BITS   = (COLUMN_BITS > GRID_BITS) ? COLUMN_BITS : GRID_BITS;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 3;
  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    MODE_GET  = 2'd0,
    MODE_SET  = 2'd1,
    MODE_UNDO = 2'd2,
    MODE_REDO = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_NOTHING = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                  mode;
    logic [ROW_BITS-1:0]    row_index;
    logic [COLUMN_BITS-1:0] column_index;
    logic [ITEM_BITS-1:0]   write_item;
  } in_req_t;

  typedef struct packed {
    logic [ITEM_BITS-1:0] read_item;
    status_t              status;
  } out_rsp_t;

endpackage

// ===== rtl/core/cell_store_with_undo_journal.sv =====
// Cell store with an undo and redo journal. Each request is a get, set, undo or redo and
// gives exactly one response. The cells sit in one synchronous memory and the journal in a
// second one (a ring of JOURNAL_DEPTH entries, each a cell address and the item it held).
// A get or set in range reads the cell, then writes back or responds; an undo or redo with
// an entry to work on reads the journal entry, reads the cell it names, then swaps both
// back. An out-of-range get or set and an undo or redo with nothing to do hand their
// response to the output register in the accept cycle. A response that cannot leave
// because the output is stalled is parked until the output frees up. One request is in
// flight at a time; the next is taken once the previous one has written its memories and
// its response has gone to the output register. After reset a clearing pass zeroes the
// cell memory one entry per cycle, all 2**(ROW_BITS+COLUMN_BITS) = 4096 entries, with in_stall
// held high; configuration writes are taken during the pass. Indices are checked against
// grid_rows and grid_columns (APB registers at byte addresses 0 and 4); undo and redo are
// not range checked.
module cell_store_with_undo_journal (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  csuj_pkg::in_req_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output csuj_pkg::out_rsp_t                   out_data,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [csuj_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [csuj_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [csuj_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);
  import csuj_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,  // post-reset sweep of the cell memory
    ST_IDLE  = 5'b00010,  // take a request, issue the first read or answer at once
    ST_JOUR  = 5'b00100,  // journal entry back, read the cell it names
    ST_CELL  = 5'b01000,  // cell data back, respond; set, undo and redo write both memories
    ST_FIN   = 5'b10000   // response parked until the output frees up
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [GRID_BITS-1:0] grid_columns_r, grid_rows_r;
  logic                 cfg_write;

  // journal bookkeeping
  logic [SLOT_BITS-1:0]  oldest_r, oldest_nxt;
  logic [COUNT_BITS-1:0] undo_count_r, undo_count_nxt;
  logic [COUNT_BITS-1:0] redo_count_r, redo_count_nxt;

  // request held while it is worked on
  in_req_t              req_r;
  logic [SLOT_BITS-1:0] slot_r, slot_nxt;
  logic                 req_load;

  // clearing pass
  logic [CELL_ADDR_BITS-1:0] clr_addr_r, clr_addr_nxt;

  // memories
  logic [ITEM_BITS-1:0]   cell_mem [0:(1 << CELL_ADDR_BITS)-1];
  logic [JENTRY_BITS-1:0] jour_mem [0:JOURNAL_DEPTH-1];
  logic [ITEM_BITS-1:0]   cell_rd_r;
  logic [JENTRY_BITS-1:0] jour_rd_r;
  logic                      cell_re, cell_we, jour_re, jour_we;
  logic [CELL_ADDR_BITS-1:0] cell_raddr, cell_waddr;
  logic [ITEM_BITS-1:0]      cell_wdata;
  logic [JENTRY_BITS-1:0]    jour_wdata;

  // output register and parked response
  logic     out_valid_r;
  out_rsp_t out_data_r, res_r, res;
  logic     res_ready, res_park, out_load, out_free;

  // request decode
  logic                      in_accept, in_range, journal_full;
  logic [CELL_ADDR_BITS-1:0] in_addr, req_addr, jour_addr;
  logic [ITEM_BITS-1:0]      jour_item;
  logic [COUNT_BITS-1:0]     ring_offset;

  // ring position of the entry offset places above the oldest one
  function automatic logic [SLOT_BITS-1:0] ring_slot(input logic [SLOT_BITS-1:0] oldest,
                                                     input logic [COUNT_BITS-1:0] offset);
    logic [COUNT_BITS:0] sum;
    sum = (COUNT_BITS+1)'(oldest) + (COUNT_BITS+1)'(offset);
    if (sum >= (COUNT_BITS+1)'(JOURNAL_DEPTH)) begin
      sum = sum - (COUNT_BITS+1)'(JOURNAL_DEPTH);
    end
    return SLOT_BITS'(sum);
  endfunction

  // ---------------------------------------------------------------- configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= GRID_RESET;
      grid_rows_r    <= GRID_RESET;
    end else if (cfg_write) begin
      case (cfg_paddr[2])
        REG_GRID_COLUMNS: grid_columns_r <= cfg_pwdata[GRID_BITS-1:0];
        REG_GRID_ROWS:    grid_rows_r    <= cfg_pwdata[GRID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_GRID_COLUMNS: cfg_prdata = CFG_DATA_BITS'(grid_columns_r);
      REG_GRID_ROWS:    cfg_prdata = CFG_DATA_BITS'(grid_rows_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- request decode
  assign in_stall     = (state_r != ST_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign in_addr      = {in_data.row_index, in_data.column_index};
  assign in_range     = (ROW_CMP_BITS'(in_data.row_index) < ROW_CMP_BITS'(grid_rows_r)) &&
                        (COL_CMP_BITS'(in_data.column_index) < COL_CMP_BITS'(grid_columns_r));
  assign journal_full = (undo_count_r >= COUNT_BITS'(JOURNAL_DEPTH));
  assign req_addr     = {req_r.row_index, req_r.column_index};
  assign jour_addr    = jour_rd_r[JENTRY_BITS-1:ITEM_BITS];
  assign jour_item    = jour_rd_r[ITEM_BITS-1:0];
  assign out_free     = !out_valid_r || !out_stall;

  // set on a full ring reuses the oldest slot; undo takes the newest undoable entry,
  // redo the one just above it
  always_comb begin
    case (in_data.mode)
      MODE_SET:  ring_offset = journal_full ? '0 : undo_count_r;
      MODE_UNDO: ring_offset = undo_count_r - COUNT_BITS'(1);
      default:   ring_offset = undo_count_r;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    oldest_nxt     = oldest_r;
    undo_count_nxt = undo_count_r;
    redo_count_nxt = redo_count_r;
    slot_nxt       = slot_r;
    req_load       = 1'b0;
    cell_re        = 1'b0;
    cell_raddr     = in_addr;
    cell_we        = 1'b0;
    cell_waddr     = req_addr;
    cell_wdata     = req_r.write_item;
    jour_re        = 1'b0;
    jour_we        = 1'b0;
    jour_wdata     = {req_addr, cell_rd_r};
    res            = '{read_item: '0, status: STATUS_DONE};
    res_ready      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        cell_we      = 1'b1;
        cell_waddr   = clr_addr_r;
        cell_wdata   = '0;
        clr_addr_nxt = clr_addr_r + CELL_ADDR_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          req_load = 1'b1;
          slot_nxt = ring_slot(oldest_r, ring_offset);
          if (in_data.mode inside {MODE_GET, MODE_SET}) begin
            if (in_range) begin
              cell_re   = 1'b1;
              state_nxt = ST_CELL;
            end else begin
              res.status = STATUS_RANGE;
              res_ready  = 1'b1;
            end
          end else if ((in_data.mode == MODE_UNDO && undo_count_r != '0) ||
                       (in_data.mode == MODE_REDO && redo_count_r != '0)) begin
            jour_re   = 1'b1;
            state_nxt = ST_JOUR;
          end else begin
            res.status = STATUS_NOTHING;
            res_ready  = 1'b1;
          end
        end
      end

      ST_JOUR: begin
        cell_re    = 1'b1;
        cell_raddr = jour_addr;
        state_nxt  = ST_CELL;
      end

      ST_CELL: begin
        res_ready = 1'b1;
        case (req_r.mode)
          MODE_GET: begin
            res.read_item = cell_rd_r;
          end
          MODE_SET: begin
            cell_we        = 1'b1;
            jour_we        = 1'b1;
            redo_count_nxt = '0;
            if (journal_full) begin
              // oldest entry is dropped
              oldest_nxt = (oldest_r == SLOT_BITS'(JOURNAL_DEPTH - 1)) ?
                           '0 : oldest_r + SLOT_BITS'(1);
            end else begin
              undo_count_nxt = undo_count_r + COUNT_BITS'(1);
            end
          end
          default: begin
            // undo and redo swap the journal entry with its cell
            cell_we    = 1'b1;
            cell_waddr = jour_addr;
            cell_wdata = jour_item;
            jour_we    = 1'b1;
            jour_wdata = {jour_addr, cell_rd_r};
            if (req_r.mode == MODE_UNDO) begin
              undo_count_nxt = undo_count_r - COUNT_BITS'(1);
              redo_count_nxt = redo_count_r + COUNT_BITS'(1);
            end else begin
              undo_count_nxt = undo_count_r + COUNT_BITS'(1);
              redo_count_nxt = redo_count_r - COUNT_BITS'(1);
            end
          end
        endcase
      end

      ST_FIN: begin
        res       = res_r;
        res_ready = 1'b1;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // hand the response to the output register, or park it
    out_load = res_ready && out_free;
    res_park = res_ready && !out_free;
    if (res_ready) begin
      state_nxt = out_free ? ST_IDLE : ST_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      oldest_r     <= '0;
      undo_count_r <= '0;
      redo_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      oldest_r     <= oldest_nxt;
      undo_count_r <= undo_count_nxt;
      redo_count_r <= redo_count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_load) begin
      req_r  <= in_data;
      slot_r <= slot_nxt;
    end
    if (res_park) begin
      res_r <= res;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_r <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (jour_we) begin
      jour_mem[slot_r] <= jour_wdata;
    end
    if (jour_re) begin
      jour_rd_r <= jour_mem[slot_nxt];
    end
  end

  // ---------------------------------------------------------------- assertions
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("request taken during clearing pass");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((COUNT_BITS+1)'(undo_count_r) + (COUNT_BITS+1)'(redo_count_r)) <=
    (COUNT_BITS+1)'(JOURNAL_DEPTH))
    else $error("undo and redo counts exceed journal depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    COUNT_BITS'(oldest_r) < COUNT_BITS'(JOURNAL_DEPTH))
    else $error("oldest journal position out of ring");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL) |=> (state_r != ST_CELL))
    else $error("memory write-back repeated");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE) || out_valid_r)
    else $error("accepted request vanished");

endmodule

// ===== verif/csuj_checker.sv =====
module csuj_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  csuj_pkg::in_req_t                  in_data,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  csuj_pkg::out_rsp_t                 out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic                               cfg_pready,
  input  logic [csuj_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [csuj_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 responses,
  output int                                 range_hits,
  output int                                 empty_hits,
  output int                                 swaps,
  output int                                 overwrites
);
  import csuj_pkg::*;

  localparam int CELL_COUNT = 2 ** CELL_ADDR_BITS;

  // shadow copy of the store, the journal ring and the grid registers
  logic [ITEM_BITS-1:0]      shadow_cells [CELL_COUNT];
  logic [CELL_ADDR_BITS-1:0] ring_addr [JOURNAL_DEPTH];
  logic [ITEM_BITS-1:0]      ring_item [JOURNAL_DEPTH];
  int                        ring_first;
  int                        undoable;
  int                        redoable;
  logic [GRID_BITS-1:0]      col_limit;
  logic [GRID_BITS-1:0]      row_limit;

  out_rsp_t awaited_responses [$];
  int       n_bad, n_rsp, n_range, n_empty, n_swap, n_over;

  function automatic int ring_pos(input int offset);
    return (ring_first + offset) % JOURNAL_DEPTH;
  endfunction

  // journal entry and its cell trade places
  function automatic void exchange_with_cell(input int slot);
    logic [ITEM_BITS-1:0] held;
    held = shadow_cells[ring_addr[slot]];
    shadow_cells[ring_addr[slot]] = ring_item[slot];
    ring_item[slot] = held;
    n_swap++;
  endfunction

  function automatic out_rsp_t cell_op_result(input in_req_t r);
    out_rsp_t                  rsp;
    logic [CELL_ADDR_BITS-1:0] addr;
    int                        slot;
    rsp.read_item = '0;
    rsp.status    = STATUS_DONE;
    case (r.mode)
      MODE_GET, MODE_SET: begin
        if (int'(r.row_index) >= int'(row_limit) || int'(r.column_index) >= int'(col_limit)) begin
          rsp.status = STATUS_RANGE;
          n_range++;
        end else begin
          addr = {r.row_index, r.column_index};
          if (r.mode == MODE_GET) begin
            rsp.read_item = shadow_cells[addr];
          end else begin
            if (undoable >= JOURNAL_DEPTH) begin
              slot = ring_first;
              ring_first = (ring_first + 1) % JOURNAL_DEPTH;
              n_over++;
            end else begin
              slot = ring_pos(undoable);
              undoable++;
            end
            ring_addr[slot] = addr;
            ring_item[slot] = shadow_cells[addr];
            shadow_cells[addr] = r.write_item;
            redoable = 0;
          end
        end
      end
      MODE_UNDO: begin
        if (undoable > 0) begin
          undoable--;
          redoable++;
          exchange_with_cell(ring_pos(undoable));
        end else begin
          rsp.status = STATUS_NOTHING;
          n_empty++;
        end
      end
      default: begin
        if (redoable > 0) begin
          exchange_with_cell(ring_pos(undoable));
          redoable--;
          undoable++;
        end else begin
          rsp.status = STATUS_NOTHING;
          n_empty++;
        end
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = '0;
      ring_first = 0;
      undoable   = 0;
      redoable   = 0;
      col_limit  = GRID_RESET;
      row_limit  = GRID_RESET;
      awaited_responses.delete();
      n_bad = 0; n_rsp = 0; n_range = 0; n_empty = 0; n_swap = 0; n_over = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_GRID_COLUMNS) col_limit = cfg_pwdata[GRID_BITS-1:0];
        else row_limit = cfg_pwdata[GRID_BITS-1:0];
      end
      // responses are matched before this edge's request is predicted
      if (out_valid && !out_stall) begin
        n_rsp++;
        if (awaited_responses.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("response %0d arrived with none outstanding", n_rsp);
        end else begin
          want = awaited_responses.pop_front();
          if (out_data.read_item !== want.read_item || out_data.status !== want.status) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch on response %0d: expected item %h status %0d, got item %h status %0d",
                       n_rsp, want.read_item, want.status, out_data.read_item, out_data.status);
          end
        end
      end
      if (in_valid && !in_stall) awaited_responses.push_back(cell_op_result(in_data));
    end
    mismatches <= n_bad;
    pending    <= awaited_responses.size();
    responses  <= n_rsp;
    range_hits <= n_range;
    empty_hits <= n_empty;
    swaps      <= n_swap;
    overwrites <= n_over;
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import csuj_pkg::*;

  // longest stretch without any handshake: the post-reset clearing pass
  localparam int STALL_LIMIT = 20000;
  // long output hold that backs the block up into its input
  localparam int HOLD_CYCLES = 300;
  // worst latency of one request plus a parked response
  localparam int SETTLE_CYCLES = 6;
  localparam int INDEX_MAX = (1 << ROW_BITS) - 1;
  localparam logic [CFG_ADDR_BITS-1:0] COLS_ADDR = {REG_GRID_COLUMNS, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] ROWS_ADDR = {REG_GRID_ROWS, 2'b00};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_req_t                  in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_rsp_t                 out_data;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  int mismatches, pending, responses, range_hits, empty_hits, swaps, overwrites;

  // stimulus-side bookkeeping
  logic quiet = 1'b0;     // end of run: no idling on either side
  logic hold_go = 1'b0;   // asks the receiver for its one long hold
  bit   calm_tx = 1'b0;   // sender stretch without gaps
  int   sent = 0;
  int   grid_settings = 0;
  int   cur_cols = 64;
  int   cur_rows = 64;

  cell_store_with_undo_journal dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // watches both channels and the register port, predicts and compares
  csuj_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .pending     (pending),
    .responses   (responses),
    .range_hits  (range_hits),
    .empty_hits  (empty_hits),
    .swaps       (swaps),
    .overwrites  (overwrites)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random stall bursts, calm stretches, one long hold
  initial begin
    int  burst;
    bit  held;
    bit  calm_rx;
    burst   = 0;
    held    = 1'b0;
    calm_rx = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
      if (hold_go && !held) begin
        // sender keeps offering meanwhile, so the block fills and stalls its input
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (!quiet && !calm_rx && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on handshakes of either channel
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("no handshake for %0d cycles, giving up", idle);
    $display("FAIL");
    $finish;
  end

  function automatic in_req_t make_req(input mode_t m, input int row, input int col,
                                       input int item);
    in_req_t r;
    r.mode         = m;
    r.row_index    = row[ROW_BITS-1:0];
    r.column_index = col[COLUMN_BITS-1:0];
    r.write_item   = item[ITEM_BITS-1:0];
    return r;
  endfunction

  // mostly a small corner of the grid so gets land on written cells; now and then any index
  function automatic int pick_index(input int limit);
    int span;
    if (limit == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, INDEX_MAX);
    span = (limit > INDEX_MAX + 1) ? INDEX_MAX + 1 : limit;
    if ($urandom_range(0, 1) == 1 && span > 4) span = 4;
    return $urandom_range(0, span - 1);
  endfunction

  function automatic int pick_item();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return (1 << ITEM_BITS) - 1;
    return $urandom_range(0, (1 << ITEM_BITS) - 1);
  endfunction

  // offer one request and hold it until taken; then maybe a gap
  task automatic issue(input in_req_t r);
    int gap;
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (!quiet && !calm_tx && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if ($urandom_range(0, 49) == 0) calm_tx = !calm_tx;
  endtask

  task automatic issue_op(input mode_t m, input int row, input int col, input int item);
    issue(make_req(m, row, col, item));
  endtask

  // drop valid and wait until every response is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access cycle; trailing idle cycle keeps back-to-back writes apart
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr, input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DATA_BITS'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input int cols, input int rows);
    settle();
    write_reg(COLS_ADDR, cols);
    write_reg(ROWS_ADDR, rows);
    cur_cols = cols;
    cur_rows = rows;
    grid_settings++;
  endtask

  // free mix of all four commands
  task automatic mixed_traffic(input int count);
    int    roll;
    mode_t m;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) m = MODE_GET;
      else if (roll < 70) m = MODE_SET;
      else if (roll < 85) m = MODE_UNDO;
      else m = MODE_REDO;
      issue_op(m, pick_index(cur_rows), pick_index(cur_cols), pick_item());
    end
  endtask

  // fill the journal past its depth, unwind it to near or past empty, then replay some or all of it
  task automatic journal_sweep();
    int n_set, n_undo, n_redo;
    n_set  = $urandom_range(JOURNAL_DEPTH + 1, JOURNAL_DEPTH + 31);
    n_undo = $urandom_range(JOURNAL_DEPTH - 4, JOURNAL_DEPTH + 6);
    n_redo = $urandom_range(20, JOURNAL_DEPTH + 6);
    repeat (n_set) issue_op(MODE_SET, pick_index(cur_rows), pick_index(cur_cols), pick_item());
    repeat (n_undo) begin
      if ($urandom_range(0, 4) == 0)
        issue_op(MODE_GET, pick_index(cur_rows), pick_index(cur_cols), pick_item());
      issue_op(MODE_UNDO, $urandom_range(0, INDEX_MAX), $urandom_range(0, INDEX_MAX), pick_item());
    end
    repeat (n_redo) begin
      if ($urandom_range(0, 4) == 0)
        issue_op(MODE_GET, pick_index(cur_rows), pick_index(cur_cols), pick_item());
      issue_op(MODE_REDO, $urandom_range(0, INDEX_MAX), $urandom_range(0, INDEX_MAX), pick_item());
    end
    // a fresh set wipes whatever was left to redo
    issue_op(MODE_SET, pick_index(cur_rows), pick_index(cur_cols), pick_item());
    issue_op(MODE_REDO, 0, 0, 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty journal on both sides, corner cells, extreme items
    issue_op(MODE_UNDO, INDEX_MAX, INDEX_MAX, 16'hffff);
    issue_op(MODE_REDO, INDEX_MAX, 0, 16'hffff);
    issue_op(MODE_GET, 0, 0, 0);
    issue_op(MODE_SET, 0, 0, 16'hffff);
    issue_op(MODE_SET, INDEX_MAX, INDEX_MAX, 16'h0001);
    issue_op(MODE_SET, INDEX_MAX, 0, 16'h8000);
    issue_op(MODE_GET, INDEX_MAX, INDEX_MAX, 0);
    issue_op(MODE_GET, 0, 0, 0);
    issue_op(MODE_UNDO, 0, 0, 0);
    issue_op(MODE_UNDO, 0, 0, 0);
    issue_op(MODE_GET, INDEX_MAX, INDEX_MAX, 0);
    issue_op(MODE_REDO, 0, 0, 0);
    issue_op(MODE_GET, INDEX_MAX, INDEX_MAX, 0);
    // writing zero empties a cell, and any set discards pending redo
    issue_op(MODE_SET, 0, INDEX_MAX, 0);
    issue_op(MODE_REDO, 0, 0, 0);

    // one-cell grid: neighbors in each dimension are out of range
    set_grid(1, 1);
    issue_op(MODE_SET, 0, 0, 16'h1234);
    issue_op(MODE_GET, 0, 1, 0);
    issue_op(MODE_SET, 1, 0, 16'h5555);
    issue_op(MODE_GET, 0, 0, 0);
    issue_op(MODE_UNDO, 0, 0, 0);

    // zero columns: every access rejected, yet undo still swaps a cell outside the grid
    set_grid(0, 127);
    issue_op(MODE_GET, 0, 0, 0);
    issue_op(MODE_SET, INDEX_MAX, INDEX_MAX, 16'haaaa);
    issue_op(MODE_UNDO, 0, 0, 0);
    set_grid(127, 0);
    issue_op(MODE_GET, 5, INDEX_MAX, 0);
    set_grid(127, 127);
    issue_op(MODE_GET, INDEX_MAX, INDEX_MAX, 0);

    // random phases over a spread of grid settings
    set_grid(64, 64);
    hold_go <= 1'b1;
    mixed_traffic(100);
    journal_sweep();
    set_grid(1, 1);
    mixed_traffic(60);
    set_grid(2, 3);
    journal_sweep();
    set_grid(0, 64);
    mixed_traffic(40);
    set_grid(64, 0);
    mixed_traffic(40);
    set_grid($urandom_range(1, 64), $urandom_range(1, 64));
    mixed_traffic(100);
    set_grid(127, 127);
    mixed_traffic(100);
    set_grid($urandom_range(1, 127), $urandom_range(1, 127));
    mixed_traffic(60);

    // last stretch runs flat out on both sides
    quiet <= 1'b1;
    set_grid(64, 64);
    mixed_traffic(120);

    settle();
    repeat (10) @(posedge clk);
    $display("run covered %0d requests, %0d responses: %0d out of range, %0d empty undo/redo",
             sent, responses, range_hits, empty_hits);
    $display("journal: %0d swaps, %0d oldest-entry overwrites, over %0d grid settings",
             swaps, overwrites, grid_settings);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
